// ===== sv/oarb_pkg.sv =====
// ----------------------------------------------------------------------------
// oarb_pkg
// Shared codes, widths and types of the overlap-add ring buffer unit.
// ----------------------------------------------------------------------------
package oarb_pkg;

  // Width of every count field and of the configuration data
  localparam int CNT_W = 11;
  // Width of the opcode field
  localparam int OP_W = 2;
  // Width of the configuration register index
  localparam int REG_INDEX_W = 1;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [REG_INDEX_W-1:0] REG_BUFFER_LENGTH = 1'd0;
  localparam logic [REG_INDEX_W-1:0] REG_HOP_LENGTH    = 1'd1;

  // Reset value of the hop length
  localparam logic [CNT_W-1:0] HOP_RESET = 11'd256;

  // Depths of the command queue and of the result buffer (powers of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int OB_DEPTH    = 2;

  // Store operation handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  // Result fields settled by the front end
  typedef struct packed {
    logic             accepted;
    logic [CNT_W-1:0] free_space;
    logic [CNT_W-1:0] readable;
  } res_info_t;

endpackage

// ===== sv/oarb_if.sv =====
// ----------------------------------------------------------------------------
// oarb_if
// Valid/ready channels of the overlap-add ring buffer unit: request elements
// in, result items out.
// ----------------------------------------------------------------------------
interface oarb_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  import oarb_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               opcode;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [CNT_W-1:0]              frame_len;
  logic                          first;

  modport source (output valid, opcode, sample, frame_len, first, input ready);
  modport sink (input valid, opcode, sample, frame_len, first, output ready);
endinterface

interface oarb_out_if #(
  parameter int STORE_BITS = 28
) ();
  import oarb_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [STORE_BITS-1:0] sample_out;
  logic                         accepted;
  logic [CNT_W-1:0]             free_space;
  logic [CNT_W-1:0]             readable;

  modport source (output valid, sample_out, accepted, free_space, readable, input ready);
  modport sink (input valid, sample_out, accepted, free_space, readable, output ready);
endinterface

// ===== sv/overlap_add_ring_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// overlap_add_ring_buffer_unit
// Overlap-add ring store for audio frames. Each input item is one element of
// a write-accumulate, read-and-clear, or clear request, and each gives one
// result item. With both sides flowing the unit takes one element per cycle:
// the front end settles pointers and the request check in the cycle it takes
// an element, and the back end does one read-modify-write of the sum store
// per cycle, forwarding the previous write; a result passes through the
// command queue, the execute stage and the result buffer. A clear request, a
// buffer_length write, and reset each start a clearing pass (one store entry
// per cycle) during which no element is taken. Any register write also holds
// off elements while the hop modulo the buffer length is recomputed one bit
// per cycle.
// ----------------------------------------------------------------------------
module overlap_add_ring_buffer_unit #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int STORE_BITS  = 28
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [oarb_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [oarb_pkg::CNT_W-1:0]       cfg_data,
  oarb_in_if.sink                          items,
  oarb_out_if.source                       results
);
  import oarb_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int KIND_W = $bits(cmd_kind_t);
  localparam int INFO_W = $bits(res_info_t);
  localparam int QW     = KIND_W + INFO_W + AW + SAMPLE_BITS;

  logic                          push;
  cmd_kind_t                     f_kind;
  res_info_t                     f_info;
  logic [AW-1:0]                 f_addr;
  logic signed [SAMPLE_BITS-1:0] f_sample;

  logic                          q_full;
  logic                          q_valid;
  logic                          q_pop;
  logic [QW-1:0]                 q_wdata;
  logic [QW-1:0]                 q_rdata;

  cmd_kind_t                     bk_kind;
  res_info_t                     bk_info;
  logic [AW-1:0]                 bk_addr;
  logic signed [SAMPLE_BITS-1:0] bk_sample;

  logic                          clearing;
  logic                          clear_start;

  // A buffer length write also clears the store
  assign clear_start = cfg_we && (cfg_index == REG_BUFFER_LENGTH);

  oarb_front #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .items      (items),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (push),
    .cmd_kind   (f_kind),
    .cmd_info   (f_info),
    .cmd_addr   (f_addr),
    .cmd_sample (f_sample)
  );

  // Pack commands through the queue
  assign q_wdata   = {f_kind, f_info, f_addr, f_sample};
  assign bk_sample = q_rdata[SAMPLE_BITS-1:0];
  assign bk_addr   = q_rdata[AW+SAMPLE_BITS-1:SAMPLE_BITS];
  assign bk_info   = q_rdata[INFO_W+AW+SAMPLE_BITS-1:AW+SAMPLE_BITS];
  assign bk_kind   = cmd_kind_t'(q_rdata[QW-1:INFO_W+AW+SAMPLE_BITS]);

  oarb_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  oarb_back #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .STORE_BITS  (STORE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clear_start (clear_start),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .cmd_kind    (bk_kind),
    .cmd_info    (bk_info),
    .cmd_addr    (bk_addr),
    .cmd_sample  (bk_sample),
    .clearing    (clearing),
    .results     (results)
  );

endmodule

// ===== sv/oarb_ram.sv =====
// ----------------------------------------------------------------------------
// oarb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// A read and a write of the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module oarb_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/oarb_queue.sv =====
// ----------------------------------------------------------------------------
// oarb_queue
// Short flop FIFO that carries store commands from the front end to the
// back end, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module oarb_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);
  import oarb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full  = (count == CNT_QW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== sv/oarb_mod.sv =====
// ----------------------------------------------------------------------------
// oarb_mod
// Restoring remainder unit, one dividend bit per cycle: gives the hop length
// modulo the buffer length for the write pointer advance.
// ----------------------------------------------------------------------------
module oarb_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [oarb_pkg::CNT_W-1:0] dividend,
  input  logic [oarb_pkg::CNT_W-1:0] divisor,
  output logic                      busy,
  output logic [oarb_pkg::CNT_W-1:0] rem
);
  import oarb_pkg::*;

  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [CNT_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [STEP_W-1:0] steps;
  logic [CNT_W:0]    trial;

  // Shift in the next dividend bit
  assign trial = {rem, dvd[CNT_W-1]};
  assign busy  = (steps != '0);

  // Load operands, then subtract where the trial fits
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      dvd   <= dividend;
      dsr   <= divisor;
      rem   <= '0;
      steps <= STEP_W'(CNT_W);
    end else if (busy) begin
      dvd   <= dvd << 1;
      steps <= steps - 1'b1;
      if (trial >= {1'b0, dsr}) begin
        rem <= CNT_W'(trial - {1'b0, dsr});
      end else begin
        rem <= CNT_W'(trial);
      end
    end
  end

endmodule

// ===== sv/oarb_front.sv =====
// ----------------------------------------------------------------------------
// oarb_front
// Front end: takes request elements, checks each request on its first
// element, keeps pointers and space count, and issues one store command
// with its result fields per element.
// ----------------------------------------------------------------------------
module oarb_front #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [oarb_pkg::REG_INDEX_W-1:0]    cfg_index,
  input  logic [oarb_pkg::CNT_W-1:0]          cfg_data,
  oarb_in_if.sink                             items,
  input  logic                                q_full,
  input  logic                                clearing,
  output logic                                push,
  output oarb_pkg::cmd_kind_t                 cmd_kind,
  output oarb_pkg::res_info_t                 cmd_info,
  output logic [$clog2(DEPTH)-1:0]            cmd_addr,
  output logic signed [SAMPLE_BITS-1:0]       cmd_sample
);
  import oarb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] BL_RESET = CNT_W'((DEPTH < 1024) ? DEPTH : 1024);

  // Configuration and request state
  logic [CNT_W-1:0] buf_len;
  logic [CNT_W-1:0] hop_len;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] wr_ptr;
  logic [CNT_W-1:0] space;
  logic [CNT_W-1:0] offset;
  logic [CNT_W-1:0] req_len;
  logic             req_ok;
  logic             req_read;
  logic             kick;

  logic [CNT_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] wr_ptr_next;
  logic [CNT_W-1:0] space_next;
  logic [CNT_W-1:0] offset_next;
  logic [CNT_W-1:0] req_len_next;
  logic             req_ok_next;
  logic             req_read_next;

  logic [CNT_W-1:0] bl_sat;
  logic [CNT_W-1:0] hop_mod;
  logic             mod_busy;
  logic             ready;
  logic [CNT_W-1:0] avail;
  logic [CNT_W:0]   waddr_sum;
  logic [CNT_W:0]   wp_sum;
  logic [CNT_W:0]   rp_inc;
  logic [CNT_W-1:0] addr_sel;
  logic             acc;

  // Hop length modulo buffer length, recomputed after every register write
  oarb_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (kick),
    .dividend (hop_len),
    .divisor  (buf_len),
    .busy     (mod_busy),
    .rem      (hop_mod)
  );

  // Stall while the remainder settles, the store clears, or the queue is full
  assign ready       = !kick && !mod_busy && !q_full && !clearing;
  assign items.ready = ready;
  assign push        = items.valid && ready;

  // Clamp buffer length writes to 1..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      bl_sat = CNT_W'(1);
    end else if (32'(cfg_data) > DEPTH) begin
      bl_sat = CNT_W'(DEPTH);
    end else begin
      bl_sat = cfg_data;
    end
  end

  assign avail = buf_len - space;

  // Classify the element and work out state updates and result fields
  always_comb begin
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    space_next    = space;
    offset_next   = offset;
    req_len_next  = req_len;
    req_ok_next   = req_ok;
    req_read_next = req_read;
    cmd_kind      = CMD_NONE;
    addr_sel      = '0;
    acc           = 1'b0;
    waddr_sum     = '0;
    wp_sum        = '0;
    rp_inc        = '0;
    if (items.opcode == OP_CLEAR) begin
      rd_ptr_next   = '0;
      wr_ptr_next   = '0;
      space_next    = buf_len;
      offset_next   = '0;
      req_len_next  = '0;
      req_ok_next   = 1'b0;
      req_read_next = 1'b0;
      cmd_kind      = CMD_CLEAR;
      acc           = 1'b1;
    end else begin
      // Open a new request on its first element
      if (items.first) begin
        offset_next  = '0;
        req_len_next = items.frame_len;
        unique case (items.opcode)
          OP_WRITE: begin
            req_read_next = 1'b0;
            req_ok_next   = (items.frame_len != '0) && (items.frame_len <= space);
          end
          OP_READ: begin
            req_read_next = 1'b1;
            req_ok_next   = (items.frame_len != '0) && (items.frame_len <= avail);
          end
          default: begin
            req_read_next = 1'b0;
            req_ok_next   = 1'b0;
          end
        endcase
      end
      if (req_ok_next && (offset_next < req_len_next)) begin
        acc = 1'b1;
        if (!req_read_next) begin
          // Write element: wrap pointer plus offset once
          cmd_kind  = CMD_WRITE;
          waddr_sum = {1'b0, wr_ptr} + {1'b0, offset_next};
          if (waddr_sum >= {1'b0, buf_len}) begin
            waddr_sum = waddr_sum - {1'b0, buf_len};
          end
          addr_sel = CNT_W'(waddr_sum);
          // Last element: advance write pointer by the hop, drop space
          if (({1'b0, offset_next} + 1'b1) == {1'b0, req_len_next}) begin
            wp_sum = {1'b0, wr_ptr} + {1'b0, hop_mod};
            if (wp_sum >= {1'b0, buf_len}) begin
              wp_sum = wp_sum - {1'b0, buf_len};
            end
            wr_ptr_next = CNT_W'(wp_sum);
            space_next  = (space > hop_len) ? (space - hop_len) : '0;
          end
        end else begin
          // Read element: take entry at read pointer and advance
          cmd_kind = CMD_READ;
          addr_sel = rd_ptr;
          rp_inc   = {1'b0, rd_ptr} + 1'b1;
          rd_ptr_next = (rp_inc == {1'b0, buf_len}) ? '0 : CNT_W'(rp_inc);
          if (space < buf_len) begin
            space_next = space + 1'b1;
          end
        end
        offset_next = offset_next + 1'b1;
      end
    end
  end

  assign cmd_addr            = AW'(addr_sel);
  assign cmd_sample          = items.sample;
  assign cmd_info.accepted   = acc;
  assign cmd_info.free_space = space_next;
  assign cmd_info.readable   = buf_len - space_next;

  // Hold configuration and request state
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len  <= BL_RESET;
      hop_len  <= HOP_RESET;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      space    <= BL_RESET;
      offset   <= '0;
      req_len  <= '0;
      req_ok   <= 1'b0;
      req_read <= 1'b0;
      kick     <= 1'b1;
    end else if (cfg_we) begin
      kick <= 1'b1;
      unique case (cfg_index)
        REG_BUFFER_LENGTH: begin
          buf_len  <= bl_sat;
          rd_ptr   <= '0;
          wr_ptr   <= '0;
          space    <= bl_sat;
          offset   <= '0;
          req_len  <= '0;
          req_ok   <= 1'b0;
          req_read <= 1'b0;
        end
        REG_HOP_LENGTH: begin
          hop_len <= cfg_data;
        end
      endcase
    end else begin
      kick <= 1'b0;
      if (push) begin
        rd_ptr   <= rd_ptr_next;
        wr_ptr   <= wr_ptr_next;
        space    <= space_next;
        offset   <= offset_next;
        req_len  <= req_len_next;
        req_ok   <= req_ok_next;
        req_read <= req_read_next;
      end
    end
  end

endmodule

// ===== sv/oarb_back.sv =====
// ----------------------------------------------------------------------------
// oarb_back
// Back end: carries out store commands as read-modify-write on the sum store
// with forwarding, runs the clearing pass, and buffers results.
// ----------------------------------------------------------------------------
module oarb_back #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int STORE_BITS  = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear_start,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  oarb_pkg::cmd_kind_t           cmd_kind,
  input  oarb_pkg::res_info_t           cmd_info,
  input  logic [$clog2(DEPTH)-1:0]      cmd_addr,
  input  logic signed [SAMPLE_BITS-1:0] cmd_sample,
  output logic                          clearing,
  oarb_out_if.source                    results
);
  import oarb_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = ((STORE_BITS > SAMPLE_BITS) ? STORE_BITS : SAMPLE_BITS) + 1;
  localparam int OBP_W = (OB_DEPTH > 1) ? $clog2(OB_DEPTH) : 1;
  localparam int OCC_W = $clog2(OB_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (STORE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  // Clearing pass
  logic [AW-1:0] clr_addr;

  // Execute stage
  logic                          b_valid;
  cmd_kind_t                     b_kind;
  res_info_t                     b_info;
  logic [AW-1:0]                 b_addr;
  logic signed [SAMPLE_BITS-1:0] b_sample;

  // Last store write, for forwarding
  logic                         fw_valid;
  logic [AW-1:0]                fw_addr;
  logic signed [STORE_BITS-1:0] fw_data;

  // Store port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic signed [STORE_BITS-1:0] ram_wdata;
  logic                         ram_re;
  logic [STORE_BITS-1:0]        ram_rdata;

  logic signed [STORE_BITS-1:0] cur;
  logic signed [SW-1:0]         sum_w;
  logic signed [STORE_BITS-1:0] sum_sat;
  logic signed [STORE_BITS-1:0] res_sample;

  // Result buffer
  logic signed [STORE_BITS-1:0] ob_sample [OB_DEPTH];
  res_info_t                    ob_info   [OB_DEPTH];
  logic [OBP_W-1:0]             ob_wr;
  logic [OBP_W-1:0]             ob_rd;
  logic [OCC_W-1:0]             ob_occ;
  logic                         drain;
  logic [OCC_W:0]               load;
  logic [OCC_W:0]               cap;

  oarb_ram #(
    .WIDTH (STORE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cmd_addr),
    .rdata (ram_rdata)
  );

  // Take a command only when its result has room and no clear is pending
  assign drain = results.valid && results.ready;
  assign load  = (OCC_W + 1)'(ob_occ) + (OCC_W + 1)'(b_valid);
  assign cap   = (OCC_W + 1)'(OB_DEPTH) + (OCC_W + 1)'(drain);
  assign q_pop = q_valid && !clearing && !(b_valid && (b_kind == CMD_CLEAR)) && (load < cap);
  assign ram_re = q_pop && ((cmd_kind == CMD_WRITE) || (cmd_kind == CMD_READ));

  // Forward the previous cycle's write over the stale read data
  assign cur = (fw_valid && (fw_addr == b_addr)) ? fw_data : $signed(ram_rdata);

  // Saturating accumulate
  assign sum_w = SW'(cur) + SW'(b_sample);
  always_comb begin
    if (sum_w > SAT_HI) begin
      sum_sat = STORE_BITS'(SAT_HI);
    end else if (sum_w < SAT_LO) begin
      sum_sat = STORE_BITS'(SAT_LO);
    end else begin
      sum_sat = STORE_BITS'(sum_w);
    end
  end

  // Select the store write: clearing pass, accumulate, or read-and-zero
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = b_addr;
    ram_wdata  = '0;
    res_sample = '0;
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (b_valid) begin
      unique case (b_kind)
        CMD_WRITE: begin
          ram_we    = 1'b1;
          ram_wdata = sum_sat;
        end
        CMD_READ: begin
          ram_we     = 1'b1;
          res_sample = cur;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  // Run the clearing pass after reset, a clear command, or a length write
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clear_start || (b_valid && (b_kind == CMD_CLEAR))) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Advance the execute stage and record the last write
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      b_valid  <= q_pop;
      fw_valid <= ram_we;
    end
    if (q_pop) begin
      b_kind   <= cmd_kind;
      b_info   <= cmd_info;
      b_addr   <= cmd_addr;
      b_sample <= cmd_sample;
    end
    fw_addr <= ram_waddr;
    fw_data <= ram_wdata;
  end

  // Buffer results
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= '0;
      ob_rd  <= '0;
      ob_occ <= '0;
    end else begin
      if (b_valid) begin
        ob_wr <= ob_wr + 1'b1;
      end
      if (drain) begin
        ob_rd <= ob_rd + 1'b1;
      end
      if (b_valid && !drain) begin
        ob_occ <= ob_occ + 1'b1;
      end else if (drain && !b_valid) begin
        ob_occ <= ob_occ - 1'b1;
      end
    end
    if (b_valid) begin
      ob_sample[ob_wr] <= res_sample;
      ob_info[ob_wr]   <= b_info;
    end
  end

  assign results.valid      = (ob_occ != '0);
  assign results.sample_out = ob_sample[ob_rd];
  assign results.accepted   = ob_info[ob_rd].accepted;
  assign results.free_space = ob_info[ob_rd].free_space;
  assign results.readable   = ob_info[ob_rd].readable;

endmodule

// ===== tb/overlap_add_ring_buffer_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overlap_add_ring_buffer_unit_test
// Self-checking test of the overlap-add ring buffer unit. Frames of write,
// read and clear requests go in; a local copy of the ring works out each
// result, and every result coming out is compared field by field in order.
// Directed frame rules, saturation, register extremes and a long output
// stall come first, then random traffic over several ring and hop settings.
// ----------------------------------------------------------------------------
module overlap_add_ring_buffer_unit_test;
  import oarb_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int STORE_BITS  = 28;

  // Opcode that the unit does not define
  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint SUM_MAX = (longint'(1) <<< (STORE_BITS - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct {
    logic [OP_W-1:0]               opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CNT_W-1:0]              frame_len;
    logic                          first;
  } element_t;

  typedef struct {
    logic signed [STORE_BITS-1:0] sample_out;
    logic                         accepted;
    logic [CNT_W-1:0]             free_space;
    logic [CNT_W-1:0]             readable;
  } outcome_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [REG_INDEX_W-1:0] cfg_index;
  logic [CNT_W-1:0]       cfg_data;

  oarb_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) items_if ();
  oarb_out_if #(.STORE_BITS(STORE_BITS)) results_if ();

  overlap_add_ring_buffer_unit #(
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .STORE_BITS (STORE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .items    (items_if),
    .results  (results_if)
  );

  // Local copy of the ring and of the frame in progress
  logic signed [STORE_BITS-1:0] ring_sums [DEPTH];
  int ring_len;
  int hop_len;
  int rd_ptr;
  int wr_ptr;
  int space_cnt;
  int elem_offset;
  int frame_total;
  bit frame_ok;
  bit frame_is_read;

  outcome_t outcomes_due [$];

  int mismatches     = 0;
  int request_count  = 0;
  int accepted_count = 0;
  int gap_pct        = 0;
  int stall_pct      = 0;
  int hold_cycles    = 0;

  // Free-running clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_ring();
    foreach (ring_sums[i]) ring_sums[i] = '0;
    rd_ptr        = 0;
    wr_ptr        = 0;
    space_cnt     = ring_len;
    elem_offset   = 0;
    frame_total   = 0;
    frame_ok      = 1'b0;
    frame_is_read = 1'b0;
  endfunction

  function automatic void set_register(logic [REG_INDEX_W-1:0] index,
                                       logic [CNT_W-1:0] data);
    if (index == REG_BUFFER_LENGTH) begin
      // Clamp the ring length, and clear as the unit does
      ring_len = (data == 0) ? 1 : (data > DEPTH) ? DEPTH : data;
      clear_ring();
    end else begin
      hop_len = data;
    end
  endfunction

  // Result of one element, advancing the local ring
  function automatic outcome_t element_outcome(element_t e);
    outcome_t r;
    int addr;
    longint total;
    r.sample_out = '0;
    r.accepted   = 1'b0;
    if (e.opcode == OP_CLEAR) begin
      clear_ring();
      r.accepted = 1'b1;
    end else begin
      // Check the whole frame on its first element
      if (e.first) begin
        elem_offset   = 0;
        frame_total   = e.frame_len;
        frame_is_read = (e.opcode == OP_READ);
        if (e.opcode == OP_WRITE) begin
          frame_ok = e.frame_len >= 1 && e.frame_len <= space_cnt;
        end else if (e.opcode == OP_READ) begin
          frame_ok = e.frame_len >= 1 && e.frame_len <= ring_len - space_cnt;
        end else begin
          frame_ok = 1'b0;
        end
      end
      if (frame_ok && elem_offset < frame_total) begin
        r.accepted = 1'b1;
        if (!frame_is_read) begin
          // Accumulate with saturation, advance by the hop on the last element
          addr  = (wr_ptr + elem_offset) % ring_len;
          total = longint'(ring_sums[addr]) + longint'(e.sample);
          if (total > SUM_MAX) total = SUM_MAX;
          else if (total < SUM_MIN) total = SUM_MIN;
          ring_sums[addr] = total[STORE_BITS-1:0];
          if (elem_offset + 1 == frame_total) begin
            wr_ptr    = (wr_ptr + hop_len) % ring_len;
            space_cnt = (space_cnt > hop_len) ? space_cnt - hop_len : 0;
          end
        end else begin
          // Read and zero the entry
          addr            = rd_ptr % ring_len;
          r.sample_out    = ring_sums[addr];
          ring_sums[addr] = '0;
          rd_ptr          = (addr + 1) % ring_len;
          if (space_cnt < ring_len) space_cnt++;
        end
        elem_offset++;
      end
    end
    r.free_space = CNT_W'(space_cnt);
    r.readable   = CNT_W'(ring_len - space_cnt);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Opcode carried by a non-first element, which the unit ignores
  function automatic logic [OP_W-1:0] later_op();
    case ($urandom_range(0, 2))
      0: return OP_WRITE;
      1: return OP_READ;
      default: return OP_UNDEFINED;
    endcase
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(logic [OP_W-1:0] opcode, logic signed [SAMPLE_BITS-1:0] sample,
                              logic [CNT_W-1:0] frame_len, logic first);
    element_t e;
    outcome_t r;
    e.opcode    = opcode;
    e.sample    = sample;
    e.frame_len = frame_len;
    e.first     = first;
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      items_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    items_if.valid     = 1'b1;
    items_if.opcode    = e.opcode;
    items_if.sample    = e.sample;
    items_if.frame_len = e.frame_len;
    items_if.first     = e.first;
    do @(posedge clk); while (!items_if.ready);
    r = element_outcome(e);
    outcomes_due.push_back(r);
    request_count++;
    if (r.accepted) accepted_count++;
  endtask

  // Send count elements of a frame; only the first carries opcode and length
  task automatic send_frame(logic [OP_W-1:0] opcode, logic [CNT_W-1:0] frame_len, int count);
    for (int i = 0; i < count; i++) begin
      if (i == 0) send_request(opcode, rand_sample(), frame_len, 1'b1);
      else send_request(later_op(), rand_sample(), CNT_W'($urandom_range(0, 2047)), 1'b0);
    end
  endtask

  // Mostly well-formed frames sized to the room left, with some noise
  task automatic send_random_frame();
    int pick;
    int room;
    int avail;
    int len;
    logic [OP_W-1:0] op;
    pick  = $urandom_range(0, 99);
    room  = space_cnt;
    avail = ring_len - space_cnt;
    len   = $urandom_range(2, 6);
    op    = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    if (pick < 45) begin
      if (room == 0 || $urandom_range(0, 9) == 0) len = room + $urandom_range(1, 4);
      else len = $urandom_range(1, room < 12 ? room : 12);
      send_frame(OP_WRITE, CNT_W'(len), len);
    end else if (pick < 87) begin
      if (avail == 0 || $urandom_range(0, 9) == 0) len = avail + $urandom_range(1, 4);
      else len = $urandom_range(1, avail < 12 ? avail : 12);
      send_frame(OP_READ, CNT_W'(len), len);
    end else if (pick < 89) begin
      send_request(OP_CLEAR, rand_sample(), CNT_W'($urandom_range(0, 2047)),
                   1'($urandom_range(0, 1)));
    end else begin
      case ($urandom_range(0, 4))
        0: send_request(OP_UNDEFINED, rand_sample(), CNT_W'($urandom_range(0, 2047)), 1'b1);
        1: send_frame(op, CNT_W'($urandom_range(0, 2047)), $urandom_range(1, 3));
        2: send_frame(op, 11'd1, 3);
        3: send_frame(OP_WRITE, CNT_W'(len), len - 1);
        default: begin
          send_frame(op, CNT_W'(len), 1);
          send_request(OP_CLEAR, rand_sample(), CNT_W'($urandom_range(0, 2047)), 1'b0);
        end
      endcase
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic wait_idle();
    @(negedge clk);
    items_if.valid = 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(logic [REG_INDEX_W-1:0] index, logic [CNT_W-1:0] data);
    wait_idle();
    // Hold off until any clearing pass or hop recompute is over
    do @(posedge clk); while (!items_if.ready);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    set_register(index, data);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("result with none expected, sample_out %0d",
                                  results_if.sample_out));
      end else begin
        want = outcomes_due.pop_front();
        if (results_if.sample_out !== want.sample_out)
          report_mismatch($sformatf("sample_out %0d, expected %0d",
                                    results_if.sample_out, want.sample_out));
        if (results_if.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %0b, expected %0b",
                                    results_if.accepted, want.accepted));
        if (results_if.free_space !== want.free_space)
          report_mismatch($sformatf("free_space %0d, expected %0d",
                                    results_if.free_space, want.free_space));
        if (results_if.readable !== want.readable)
          report_mismatch($sformatf("readable %0d, expected %0d",
                                    results_if.readable, want.readable));
      end
    end
  end

  // Output side: random stall bursts, or one long hold when asked
  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        results_if.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        results_if.ready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        results_if.ready = 1'b1;
      end
    end
  end

  task automatic test_frame_rules();
    gap_pct   = 10;
    stall_pct = 10;
    // Write frame of four; later opcodes and lengths are ignored
    send_request(OP_WRITE, SAMPLE_MAX, 11'd4, 1'b1);
    send_request(OP_READ, SAMPLE_MIN, 11'd0, 1'b0);
    send_request(OP_UNDEFINED, '0, 11'd2047, 1'b0);
    send_request(OP_WRITE, -24'sd1, 11'd1, 1'b0);
    // Refuse the element past the frame end
    send_request(OP_WRITE, 24'sd5, 11'd1, 1'b0);
    // Refuse zero, oversized and undefined frames
    send_request(OP_WRITE, 24'sd7, 11'd0, 1'b1);
    send_request(OP_WRITE, 24'sd7, 11'd2047, 1'b1);
    send_request(OP_UNDEFINED, 24'sd7, 11'd1, 1'b1);
    send_request(OP_READ, '0, 11'd1024, 1'b1);
    send_request(OP_READ, '0, 11'd0, 1'b1);
    // Read back the four sums
    send_request(OP_READ, '0, 11'd4, 1'b1);
    send_request(OP_UNDEFINED, '0, 11'd0, 1'b0);
    send_request(OP_WRITE, '0, 11'd0, 1'b0);
    send_request(OP_READ, '0, 11'd0, 1'b0);
    // Abandon a write frame part way; only the next one advances
    send_request(OP_WRITE, 24'sd100, 11'd3, 1'b1);
    send_request(OP_WRITE, 24'sd200, 11'd0, 1'b0);
    send_request(OP_WRITE, 24'sd300, 11'd2, 1'b1);
    send_request(OP_WRITE, 24'sd400, 11'd0, 1'b0);
    // Clear inside a frame, then on a first element
    send_request(OP_WRITE, SAMPLE_MAX, 11'd3, 1'b1);
    send_request(OP_CLEAR, '0, 11'd0, 1'b0);
    send_request(OP_WRITE, SAMPLE_MAX, 11'd0, 1'b0);
    send_request(OP_CLEAR, SAMPLE_MIN, 11'd1024, 1'b1);
    send_request(OP_READ, '0, 11'd1, 1'b1);
  endtask

  task automatic test_saturation();
    gap_pct   = 10;
    stall_pct = 10;
    write_register(REG_BUFFER_LENGTH, 11'd4);
    write_register(REG_HOP_LENGTH, 11'd0);
    // Pile extremes onto the same two entries until they clip
    repeat (17) begin
      send_request(OP_WRITE, SAMPLE_MAX, 11'd2, 1'b1);
      send_request(OP_WRITE, SAMPLE_MIN, 11'd0, 1'b0);
    end
    write_register(REG_HOP_LENGTH, 11'd2);
    send_request(OP_WRITE, SAMPLE_MAX, 11'd2, 1'b1);
    send_request(OP_WRITE, SAMPLE_MIN, 11'd0, 1'b0);
    send_frame(OP_READ, 11'd2, 2);
  endtask

  task automatic test_register_extremes();
    gap_pct   = 5;
    stall_pct = 5;
    // One-entry ring with the widest hop
    write_register(REG_HOP_LENGTH, 11'd2047);
    write_register(REG_BUFFER_LENGTH, 11'd0);
    send_frame(OP_WRITE, 11'd1, 1);
    send_frame(OP_READ, 11'd1, 1);
    send_frame(OP_WRITE, 11'd1, 1);
    send_frame(OP_WRITE, 11'd1, 1);
    send_frame(OP_READ, 11'd1, 1);
    // Clamped full ring: whole-ring frames are checked, a ring-sized hop wraps
    write_register(REG_BUFFER_LENGTH, 11'd2047);
    write_register(REG_HOP_LENGTH, 11'd1024);
    send_frame(OP_WRITE, 11'd1025, 1);
    send_frame(OP_WRITE, 11'd1024, 2);
    send_frame(OP_WRITE, 11'd2, 2);
    send_frame(OP_READ, 11'd1024, 3);
    send_frame(OP_READ, 11'd1022, 1);
    send_frame(OP_READ, 11'd1021, 2);
    write_register(REG_HOP_LENGTH, 11'd2047);
    send_frame(OP_WRITE, 11'd3, 3);
    send_frame(OP_READ, 11'd3, 3);
  endtask

  task automatic test_backpressure();
    int start;
    write_register(REG_BUFFER_LENGTH, 11'd64);
    write_register(REG_HOP_LENGTH, 11'd8);
    gap_pct     = 0;
    stall_pct   = 0;
    hold_cycles = 300;
    start       = request_count;
    while (request_count - start < 80) send_random_frame();
  endtask

  task automatic run_phase(int length, int hop, int count, int gap, int stall);
    int start;
    write_register(REG_BUFFER_LENGTH, CNT_W'(length));
    write_register(REG_HOP_LENGTH, CNT_W'(hop));
    gap_pct   = gap;
    stall_pct = stall;
    start     = accepted_count;
    while (accepted_count - start < count) send_random_frame();
  endtask

  task automatic test_random_traffic();
    run_phase(16, 4, 240, 20, 20);
    run_phase(7, 3, 190, 30, 10);
    run_phase(64, 16, 240, 10, 30);
    run_phase(32, 40, 190, 20, 20);
    run_phase(1024, 256, 170, 15, 15);
    run_phase(5, 0, 130, 20, 20);
    run_phase(24, 6, 170, 0, 0);
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_BUFFER_LENGTH;
    cfg_data           = '0;
    items_if.valid     = 1'b0;
    items_if.opcode    = OP_WRITE;
    items_if.sample    = '0;
    items_if.frame_len = '0;
    items_if.first     = 1'b0;
    ring_len           = DEPTH;
    hop_len            = HOP_RESET;
    clear_ring();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_frame_rules();
    test_saturation();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
sv/oarb_pkg.sv
sv/oarb_if.sv
sv/oarb_ram.sv
sv/oarb_queue.sv
sv/oarb_mod.sv
sv/oarb_front.sv
sv/oarb_back.sv
sv/overlap_add_ring_buffer_unit.sv
tb/overlap_add_ring_buffer_unit_test.sv
